// ===== hdl/lcdx_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdx_pkg
// Shared types, constants and the init command table of the character LCD
// expander sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdx_pkg;

  // default geometry and queue size
  localparam int DEF_ROWS        = 2;
  localparam int DEF_COLUMNS     = 16;
  localparam int DEF_QUEUE_DEPTH = 2;

  // operation codes
  localparam logic [2:0] MODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_PRINT  = 3'd1;
  localparam logic [2:0] MODE_CMD    = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_CURSOR = 3'd4;

  // lcd command bytes
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [6:0] ROW_STRIDE     = 7'h40;

  // expander shadow value at the start of init
  localparam logic [7:0] BL_ONLY = 8'h08;

  // init sequence
  localparam logic [2:0] INIT_LAST = 3'd6;

  // delays in ms
  localparam logic [4:0] WAIT_POWER_ON = 5'd16;
  localparam logic [4:0] WAIT_NONE     = 5'd0;
  localparam logic [2:0] WAIT_RESET1   = 3'd6;
  localparam logic [2:0] WAIT_RESET2   = 3'd2;
  localparam logic [2:0] WAIT_NORMAL   = 3'd1;

  // one queued lcd byte job
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h03;
      3'd1:    r = 8'h03;
      3'd2:    r = 8'h02;
      3'd3:    r = 8'h28;
      3'd4:    r = 8'h01;
      3'd5:    r = 8'h0C;
      default: r = 8'h06;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lcdx_front.sv =====
// ----------------------------------------------------------------------------
// lcdx_front
// Classifies an incoming operation into one queued byte job and drops
// operations that give no output.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdx_front #(
  parameter int ROWS    = lcdx_pkg::DEF_ROWS,
  parameter int COLUMNS = lcdx_pkg::DEF_COLUMNS
) (
  input  wire logic          push,
  input  wire logic [2:0]    mode,
  input  wire logic [7:0]    value,
  input  wire logic [1:0]    row,
  input  wire logic [4:0]    column,
  input  wire logic          q_full,
  output lcdx_pkg::cmd_t     q_cmd,
  output logic               q_push
);

  logic       ok;
  logic [6:0] addr;

  always_comb begin
    addr = 7'({5'd0, row} * lcdx_pkg::ROW_STRIDE) + {2'd0, column};
    ok = 1'b1;
    q_cmd.is_init = 1'b0;
    q_cmd.rs = 1'b0;
    q_cmd.data = value;
    unique case (mode)
      lcdx_pkg::MODE_INIT: begin
        q_cmd.is_init = 1'b1;
      end
      lcdx_pkg::MODE_PRINT: begin
        q_cmd.rs = 1'b1;
      end
      lcdx_pkg::MODE_CMD: begin
        q_cmd.rs = 1'b0;
      end
      lcdx_pkg::MODE_CLEAR: begin
        q_cmd.data = lcdx_pkg::CMD_CLEAR;
      end
      lcdx_pkg::MODE_CURSOR: begin
        q_cmd.data = lcdx_pkg::CMD_SET_DDRAM | {1'b0, addr};
        ok = (32'(row) < ROWS) && (32'(column) < COLUMNS);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    q_push = push && !q_full && ok;
  end

endmodule

`default_nettype wire

// ===== hdl/lcdx_queue.sv =====
// ----------------------------------------------------------------------------
// lcdx_queue
// Small job queue between the front classifier and the write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdx_queue #(
  parameter int DEPTH = lcdx_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr,
  input  wire lcdx_pkg::cmd_t wr_data,
  input  wire logic           rd,
  output lcdx_pkg::cmd_t      rd_data,
  output logic                full,
  output logic                valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lcdx_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lcdx_back.sv =====
// ----------------------------------------------------------------------------
// lcdx_back
// Write sequencer: turns queued byte jobs into expander writes, four per
// lcd byte, and keeps the expander shadow.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdx_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire lcdx_pkg::cmd_t q_cmd,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output logic [7:0]          expander_byte,
  output logic [4:0]          wait_before_ms,
  output logic [2:0]          wait_after_ms,
  output logic                last
);

  lcdx_pkg::back_state_t state;
  lcdx_pkg::cmd_t        job;
  logic [2:0]            byte_idx;
  logic [1:0]            step;
  logic [7:0]            shadow;
  logic                  out_valid;

  logic [7:0] cur_byte;
  logic [3:0] nib;
  logic [3:0] low_base;
  logic       first;
  logic [7:0] wr_byte;
  logic [4:0] wr_before;
  logic [2:0] wr_after;
  logic       wr_last;
  logic       adv;
  logic       load;

  always_comb begin
    cur_byte = job.is_init ? lcdx_pkg::init_cmd(byte_idx) : job.data;
    nib      = step[1] ? cur_byte[3:0] : cur_byte[7:4];
    first    = job.is_init && (byte_idx == 3'd0) && (step == 2'd0);
    low_base = first ? lcdx_pkg::BL_ONLY[3:0] : shadow[3:0];
    // en high write, then the same nibble with en low
    if (!step[0]) begin
      wr_byte = {nib, low_base[3], 1'b1, low_base[1], job.rs};
    end else begin
      wr_byte = {shadow[7:4], shadow[3], 1'b0, shadow[1:0]};
    end
    wr_before = first ? lcdx_pkg::WAIT_POWER_ON : lcdx_pkg::WAIT_NONE;
    wr_after  = lcdx_pkg::WAIT_NORMAL;
    if (job.is_init && step == 2'd3 && byte_idx == 3'd0) begin
      wr_after = lcdx_pkg::WAIT_RESET1;
    end else if (job.is_init && step == 2'd3 && byte_idx == 3'd1) begin
      wr_after = lcdx_pkg::WAIT_RESET2;
    end
    wr_last = (step == 2'd3) && (!job.is_init || byte_idx == lcdx_pkg::INIT_LAST);
    adv     = (state == lcdx_pkg::ST_RUN) && (!out_valid || pop);
    load    = q_valid && ((state == lcdx_pkg::ST_IDLE) || (adv && wr_last));
    q_pop   = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lcdx_pkg::ST_IDLE;
      byte_idx  <= '0;
      step      <= '0;
      shadow    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        shadow    <= wr_byte;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        state    <= lcdx_pkg::ST_RUN;
        byte_idx <= '0;
        step     <= '0;
      end else if (adv) begin
        unique case (state)
          lcdx_pkg::ST_RUN: begin
            if (wr_last) begin
              state <= lcdx_pkg::ST_IDLE;
            end
            step <= step + 2'd1;
            if (step == 2'd3) begin
              byte_idx <= byte_idx + 3'd1;
            end
          end
          default: begin
            state <= lcdx_pkg::ST_IDLE;
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      job <= q_cmd;
    end
    if (adv) begin
      expander_byte  <= wr_byte;
      wait_before_ms <= wr_before;
      wait_after_ms  <= wr_after;
      last           <= wr_last;
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== hdl/char_lcd_i2c_expander_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_i2c_expander_sequencer
// Turns character LCD operations into port expander writes for a 4-bit LCD
// behind an I2C expander, with millisecond delays and an end marker.
//
//   channel  | handshake      | fields
//   ---------+----------------+------------------------------------------------
//   input    | push / full    | mode, value, row, column
//   result   | empty / pop    | expander_byte, wait_before_ms, wait_after_ms, last
//
// One write leaves the sequencer per cycle while the result side does not stall;
// the write sequencer sets this, back to back across items.
// Dropped operations (bad cursor, unused mode) skip the queue and give no output.
// Input is taken while the job queue has room, even while results stall.
// Synchronous reset empties the queue, idles the sequencer and zeroes the shadow.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_i2c_expander_sequencer #(
  parameter int ROWS        = lcdx_pkg::DEF_ROWS,
  parameter int COLUMNS     = lcdx_pkg::DEF_COLUMNS,
  parameter int QUEUE_DEPTH = lcdx_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [2:0] mode,
  input  wire logic [7:0] value,
  input  wire logic [1:0] row,
  input  wire logic [4:0] column,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      expander_byte,
  output logic [4:0]      wait_before_ms,
  output logic [2:0]      wait_after_ms,
  output logic            last
);

  lcdx_pkg::cmd_t f_cmd;
  lcdx_pkg::cmd_t q_cmd;
  logic           f_push;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;

  lcdx_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .push   (push),
    .mode   (mode),
    .value  (value),
    .row    (row),
    .column (column),
    .q_full (q_full),
    .q_cmd  (f_cmd),
    .q_push (f_push)
  );

  lcdx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .wr_data (f_cmd),
    .rd      (q_pop),
    .rd_data (q_cmd),
    .full    (q_full),
    .valid   (q_valid)
  );

  lcdx_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .expander_byte  (expander_byte),
    .wait_before_ms (wait_before_ms),
    .wait_after_ms  (wait_after_ms),
    .last           (last)
  );

  assign full = q_full;

`ifndef NO_ASSERTIONS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !f_push) else $error("job queue written while full");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("job taken from empty queue");

  a_power_on_write: assert property (@(posedge clk) disable iff (rst)
    (!empty && wait_before_ms != 5'd0) |-> (expander_byte == 8'h0C))
    else $error("power-on delay on wrong write");

  a_last_en_low: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> !expander_byte[2])
    else $error("final write leaves enable high");
`endif

endmodule

`default_nettype wire

// ===== tb/char_lcd_i2c_expander_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_i2c_expander_sequencer_tb
// Feeds LCD operations into the expander sequencer and checks every expander
// write it hands back. A directed walk covers the field extremes, each mode,
// rejected cursor positions and unused modes; a random stream follows. An
// in-bench model of the shadow register predicts every write, and both sides
// of the block are throttled at random, with one long output stall and one
// full drain.
// ----------------------------------------------------------------------------

module char_lcd_i2c_expander_sequencer_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_OPS  = 305;
  localparam int MAX_REPORTS = 10;

  localparam int RS_BIT = 0;
  localparam int EN_BIT = 2;

  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  localparam logic [6:0][7:0] POWER_UP_BYTES =
    {8'h03, 8'h03, 8'h02, 8'h28, 8'h01, 8'h0C, 8'h06};

  typedef struct packed {
    logic [7:0] data;
    logic [4:0] before_ms;
    logic [2:0] after_ms;
    logic       last;
  } exp_write_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] value;
    logic [1:0] row;
    logic [4:0] column;
    logic       typed;
    logic [4:0] nres;
    logic [7:0] first_byte;
  } op_row_t;

  localparam int N_DIRECTED = 25;

  op_row_t directed_ops [0:N_DIRECTED-1] = '{
    '{lcdx_pkg::MODE_PRINT,  8'h00, 2'd0, 5'd0,  1'b1, 5'd4,  8'h05},
    '{lcdx_pkg::MODE_CMD,    8'hFF, 2'd0, 5'd0,  1'b1, 5'd4,  8'hF4},
    '{lcdx_pkg::MODE_CLEAR,  8'h00, 2'd3, 5'd31, 1'b0, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_CURSOR, 8'h00, 2'd2, 5'd0,  1'b1, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_CURSOR, 8'h00, 2'd0, 5'd16, 1'b1, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_CURSOR, 8'hFF, 2'd3, 5'd31, 1'b1, 5'd0,  8'h00},
    '{MODE_SPARE5,           8'h41, 2'd0, 5'd0,  1'b1, 5'd0,  8'h00},
    '{MODE_SPARE6,           8'h00, 2'd1, 5'd3,  1'b1, 5'd0,  8'h00},
    '{MODE_SPARE7,           8'hFF, 2'd3, 5'd31, 1'b1, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_INIT,   8'hFF, 2'd3, 5'd31, 1'b1, 5'd28, 8'h0C},
    '{lcdx_pkg::MODE_PRINT,  8'hFF, 2'd1, 5'd1,  1'b1, 5'd4,  8'hFD},
    '{lcdx_pkg::MODE_PRINT,  8'h00, 2'd0, 5'd0,  1'b1, 5'd4,  8'h0D},
    '{lcdx_pkg::MODE_CMD,    8'h00, 2'd0, 5'd0,  1'b0, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_CMD,    8'h80, 2'd2, 5'd20, 1'b0, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_CURSOR, 8'h00, 2'd0, 5'd0,  1'b0, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_CURSOR, 8'h00, 2'd1, 5'd15, 1'b0, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_CURSOR, 8'hFF, 2'd0, 5'd15, 1'b0, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_CURSOR, 8'h00, 2'd1, 5'd0,  1'b0, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_CURSOR, 8'h00, 2'd1, 5'd16, 1'b1, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_CURSOR, 8'h00, 2'd0, 5'd31, 1'b1, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_PRINT,  8'hA5, 2'd2, 5'd10, 1'b0, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_CMD,    8'h5A, 2'd1, 5'd21, 1'b0, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_CLEAR,  8'hFF, 2'd0, 5'd0,  1'b0, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_INIT,   8'h00, 2'd0, 5'd0,  1'b0, 5'd0,  8'h00},
    '{lcdx_pkg::MODE_PRINT,  8'h7E, 2'd0, 5'd0,  1'b0, 5'd0,  8'h00}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [2:0] mode = '0;
  logic [7:0] value = '0;
  logic [1:0] row = '0;
  logic [4:0] column = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] expander_byte;
  logic [4:0] wait_before_ms;
  logic [2:0] wait_after_ms;
  logic       last;

  // tags that travel with the offered item
  logic       tag_typed = 1'b0;
  logic [4:0] tag_nres = '0;
  logic [7:0] tag_first = '0;

  logic [7:0] panel_shadow = '0;
  exp_write_t op_writes [0:27];
  int         op_count;
  exp_write_t expected_writes [$];

  int  errors = 0;
  int  idle_cycles = 0;
  int  writes_checked = 0;
  int  ops_seen = 0;
  int  inits_seen = 0;
  int  dropped_seen = 0;
  bit  hold_req = 1'b0;
  bit  sender_burst = 1'b0;
  bit  reader_burst = 1'b0;

  char_lcd_i2c_expander_sequencer DUT (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .mode           (mode),
    .value          (value),
    .row            (row),
    .column         (column),
    .empty          (empty),
    .pop            (pop),
    .expander_byte  (expander_byte),
    .wait_before_ms (wait_before_ms),
    .wait_after_ms  (wait_after_ms),
    .last           (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(input bit burst);
    int p;
    if (burst) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // one lcd byte as four expander writes
  task automatic shift_out_byte(input logic rs, input logic [7:0] b);
    logic [3:0] nib;
    panel_shadow[RS_BIT] = rs;
    for (int h = 0; h < 2; h++) begin
      nib = (h == 0) ? b[7:4] : b[3:0];
      panel_shadow = {nib, panel_shadow[3:0]};
      panel_shadow[EN_BIT] = 1'b1;
      op_writes[op_count] = '{panel_shadow, lcdx_pkg::WAIT_NONE, lcdx_pkg::WAIT_NORMAL, 1'b0};
      op_count++;
      panel_shadow[EN_BIT] = 1'b0;
      op_writes[op_count] = '{panel_shadow, lcdx_pkg::WAIT_NONE, lcdx_pkg::WAIT_NORMAL, 1'b0};
      op_count++;
    end
  endtask

  task automatic predict_writes(input logic [2:0] m, input logic [7:0] v,
                                input logic [1:0] r, input logic [4:0] c,
                                input logic typed, input logic [4:0] nres,
                                input logic [7:0] first_byte);
    logic [6:0] addr;
    op_count = 0;
    case (m)
      lcdx_pkg::MODE_INIT: begin
        panel_shadow = lcdx_pkg::BL_ONLY;
        for (int i = 0; i < 7; i++) shift_out_byte(1'b0, POWER_UP_BYTES[6-i]);
        op_writes[0].before_ms = lcdx_pkg::WAIT_POWER_ON;
        op_writes[3].after_ms  = lcdx_pkg::WAIT_RESET1;
        op_writes[7].after_ms  = lcdx_pkg::WAIT_RESET2;
      end
      lcdx_pkg::MODE_PRINT: shift_out_byte(1'b1, v);
      lcdx_pkg::MODE_CMD:   shift_out_byte(1'b0, v);
      lcdx_pkg::MODE_CLEAR: shift_out_byte(1'b0, lcdx_pkg::CMD_CLEAR);
      lcdx_pkg::MODE_CURSOR: begin
        if (r < lcdx_pkg::DEF_ROWS && c < lcdx_pkg::DEF_COLUMNS) begin
          addr = r * lcdx_pkg::ROW_STRIDE + c;
          shift_out_byte(1'b0, lcdx_pkg::CMD_SET_DDRAM | {1'b0, addr});
        end
      end
      default: ;
    endcase
    if (op_count > 0) op_writes[op_count-1].last = 1'b1;
    if (typed) begin
      if (nres == 0) op_count = 0;
      else op_writes[0].data = first_byte;
    end
    ops_seen++;
    if (m == lcdx_pkg::MODE_INIT) inits_seen++;
    if (op_count == 0) dropped_seen++;
    for (int i = 0; i < op_count; i++) expected_writes.push_back(op_writes[i]);
  endtask

  // checker and predictor, both sampled at the clock edge
  always @(posedge clk) begin : monitor
    exp_write_t got;
    exp_write_t want;
    if (!rst) begin
      if (pop && !empty) begin
        got = '{expander_byte, wait_before_ms, wait_after_ms, last};
        writes_checked++;
        if (expected_writes.size() == 0) begin
          flag_error($sformatf("unexpected write byte %02h before %0d after %0d last %0d",
                               got.data, got.before_ms, got.after_ms, got.last));
        end else begin
          want = expected_writes.pop_front();
          if (got != want)
            flag_error($sformatf({"write exp byte %02h before %0d after %0d last %0d, ",
                                  "got byte %02h before %0d after %0d last %0d"},
                                 want.data, want.before_ms, want.after_ms, want.last,
                                 got.data, got.before_ms, got.after_ms, got.last));
        end
      end
      if (push && !full)
        predict_writes(mode, value, row, column, tag_typed, tag_nres, tag_first);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("char_lcd_i2c_expander_sequencer: mismatch");
    $finish;
  end

  // result side
  initial begin : reader
    int stall;
    int run;
    stall = 0;
    run = 0;
    forever begin
      @(posedge clk);
      run++;
      if (run % 70 == 0) reader_burst = ($urandom_range(0, 2) == 0);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap(reader_burst);
      end
    end
  end

  task automatic offer(input logic [2:0] m, input logic [7:0] v, input logic [1:0] r,
                       input logic [4:0] c, input logic typed, input logic [4:0] nres,
                       input logic [7:0] first_byte);
    int gap;
    mode      <= m;
    value     <= v;
    row       <= r;
    column    <= c;
    tag_typed <= typed;
    tag_nres  <= nres;
    tag_first <= first_byte;
    push      <= 1'b1;
    do @(posedge clk); while (full);
    gap = pick_gap(sender_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : sender
    int sent;
    int p;
    logic [2:0] m;
    logic [7:0] v;
    logic [1:0] r;
    logic [4:0] c;
    sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      offer(directed_ops[i].mode, directed_ops[i].value, directed_ops[i].row,
            directed_ops[i].column, directed_ops[i].typed, directed_ops[i].nres,
            directed_ops[i].first_byte);

    while (sent < RANDOM_OPS) begin
      v = 8'($urandom_range(0, 255));
      r = 2'($urandom_range(0, 3));
      c = 5'($urandom_range(0, 31));
      p = $urandom_range(0, 99);
      if (p < 4) m = lcdx_pkg::MODE_INIT;
      else if (p < 34) m = lcdx_pkg::MODE_PRINT;
      else if (p < 56) m = lcdx_pkg::MODE_CMD;
      else if (p < 66) m = lcdx_pkg::MODE_CLEAR;
      else if (p < 95) m = lcdx_pkg::MODE_CURSOR;
      else m = 3'($urandom_range(MODE_SPARE5, MODE_SPARE7));
      // mostly on-screen cursor positions
      if (m == lcdx_pkg::MODE_CURSOR && p < 88) begin
        r = 2'($urandom_range(0, lcdx_pkg::DEF_ROWS - 1));
        c = 5'($urandom_range(0, lcdx_pkg::DEF_COLUMNS - 1));
      end
      sent++;
      if (sent % 40 == 0) sender_burst = ($urandom_range(0, 2) == 0);
      if (sent == 120) hold_req = 1'b1;
      if (sent == 240) begin
        push <= 1'b0;
        @(posedge clk);
        while (expected_writes.size() != 0) @(posedge clk);
      end
      offer(m, v, r, c, 1'b0, 5'd0, 8'h00);
    end

    push <= 1'b0;
    @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d operations (%0d init, %0d without output), %0d writes checked",
             ops_seen, inits_seen, dropped_seen, writes_checked);
    if (errors > MAX_REPORTS) $display("%0d mismatches in total", errors);
    if (errors == 0) begin
      $display("char_lcd_i2c_expander_sequencer: match");
    end else begin
      $display("char_lcd_i2c_expander_sequencer: mismatch");
    end
    $finish;
  end

endmodule
